>>> hw/rtl/tsc_pkg.sv
// Shared constants and codes for the thresholded spot centroid block.
`timescale 1ns / 1ps

package tsc_pkg;

  localparam int PIX_W       = 8;
  localparam int THRESH_W    = 8;
  localparam int ROW_WIDTH_W = 11;
  localparam int WS_W        = 28;   // weight sum
  localparam int ACC_W       = 39;   // weighted column / row sums
  localparam int OUT_W       = 18;   // centroid coordinate
  localparam int PIX_MAX     = 255;

  localparam int DEF_MAX_COLS  = 1024;
  localparam int DEF_MAX_ROWS  = 1024;
  localparam int DEF_FRAC_BITS = 8;
  localparam int QUEUE_DEPTH   = 4;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = ROW_WIDTH_W;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'b1;

  localparam logic [THRESH_W-1:0]    THRESH_RST    = 8'd128;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 11'd1024;

endpackage

>>> hw/rtl/tsc_fifo.sv
// Short flip-flop queue between the pixel front end and the accumulator back end.
`timescale 1ns / 1ps

module tsc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]    count_r;

  assign full     = (count_r == NW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + NW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/tsc_front.sv
// Front end: pixel position tracking, threshold test and weighting products.
`timescale 1ns / 1ps

module tsc_front
  import tsc_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int CW = $clog2(MAX_COLS),
  parameter int RW = $clog2(MAX_ROWS),
  parameter int IW = 1 + PIX_W + (PIX_W + CW) + (PIX_W + RW)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [THRESH_W-1:0]    threshold,
  input  logic [ROW_WIDTH_W-1:0] row_width,
  input  logic                   in_valid,
  input  logic [PIX_W-1:0]       in_pixel_value,
  input  logic                   in_frame_end,
  input  logic                   q_full,
  output logic                   in_stall,
  output logic                   q_push,
  output logic [IW-1:0]          q_data
);

  localparam int WW   = $clog2(MAX_COLS + 1);
  localparam int CMPW = (WW > ROW_WIDTH_W) ? WW : ROW_WIDTH_W;

  logic [CW-1:0]        col_r, col_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic [CMPW-1:0]      rw_ext, width_c, col_inc;
  logic                 wrap, counted;
  logic [PIX_W-1:0]     weight;
  logic [PIX_W+CW-1:0]  wcol;
  logic [PIX_W+RW-1:0]  wrow;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    rw_ext = CMPW'(row_width);
    if (rw_ext == '0) begin
      width_c = CMPW'(1);
    end else if (rw_ext > CMPW'(MAX_COLS)) begin
      width_c = CMPW'(MAX_COLS);
    end else begin
      width_c = rw_ext;
    end
    col_inc = CMPW'(col_r) + CMPW'(1);
    wrap    = (col_inc >= width_c);
    col_nxt = wrap ? '0 : col_inc[CW-1:0];
    row_nxt = row_r;
    if (wrap && row_r < RW'(MAX_ROWS - 1)) begin
      row_nxt = row_r + RW'(1);
    end

    counted = (in_pixel_value <= threshold);
    weight  = counted ? PIX_W'(PIX_MAX) - in_pixel_value : '0;
    wcol    = (PIX_W + CW)'(weight) * (PIX_W + CW)'(col_r);
    wrow    = (PIX_W + RW)'(weight) * (PIX_W + RW)'(row_r);
    q_data  = {in_frame_end, weight, wcol, wrow};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (q_push) begin
      if (in_frame_end) begin
        col_r <= '0;
        row_r <= '0;
      end else begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

endmodule

>>> hw/rtl/tsc_div.sv
// Restoring divider, one quotient bit a cycle, saturating at the coordinate range.
`timescale 1ns / 1ps

module tsc_div
  import tsc_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ACC_W-1:0] num,
  input  logic [WS_W-1:0]  den,
  input  logic             ack,
  output logic             res_valid,
  output logic [OUT_W-1:0] quot
);

  localparam int NUMW = ACC_W + FRAC_BITS;
  localparam int DW   = WS_W + OUT_W;
  localparam int RMW  = (NUMW > DW) ? NUMW : DW;
  localparam int CNTW = $clog2(OUT_W + 1);

  typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;

  state_t           state_r;
  logic [RMW-1:0]   rem_r, dsh_r;
  logic [OUT_W-1:0] q_r;
  logic [CNTW-1:0]  cnt_r;

  logic [RMW-1:0] dividend, dlim, rem_sub;
  logic           ge;

  always_comb begin
    dividend = RMW'(num) << FRAC_BITS;
    dlim     = RMW'(den) << OUT_W;
    ge       = (rem_r >= dsh_r);
    rem_sub  = rem_r - dsh_r;
  end

  assign res_valid = (state_r == DONE);
  assign quot      = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        IDLE: begin
          if (start) begin
            if (dividend >= dlim) begin
              // quotient would not fit: clamp to full scale
              q_r     <= '1;
              state_r <= DONE;
            end else begin
              rem_r   <= dividend;
              dsh_r   <= RMW'(den) << (OUT_W - 1);
              q_r     <= '0;
              cnt_r   <= CNTW'(OUT_W);
              state_r <= RUN;
            end
          end
        end
        RUN: begin
          if (ge) begin
            rem_r <= rem_sub;
          end
          q_r   <= {q_r[OUT_W-2:0], ge};
          dsh_r <= dsh_r >> 1;
          cnt_r <= cnt_r - CNTW'(1);
          if (cnt_r == CNTW'(1)) begin
            state_r <= DONE;
          end
        end
        DONE: begin
          if (ack) begin
            state_r <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/tsc_back.sv
// Back end: saturating accumulators, frame-end division and output register.
`timescale 1ns / 1ps

module tsc_back
  import tsc_pkg::*;
#(
  parameter int MAX_COLS  = DEF_MAX_COLS,
  parameter int MAX_ROWS  = DEF_MAX_ROWS,
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int CW = $clog2(MAX_COLS),
  parameter int RW = $clog2(MAX_ROWS),
  parameter int IW = 1 + PIX_W + (PIX_W + CW) + (PIX_W + RW)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  logic [IW-1:0]    q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] out_centroid_x,
  output logic [OUT_W-1:0] out_centroid_y,
  output logic             out_no_spot
);

  logic                 it_last;
  logic [PIX_W-1:0]     it_weight;
  logic [PIX_W+CW-1:0]  it_wcol;
  logic [PIX_W+RW-1:0]  it_wrow;

  logic [WS_W-1:0]  ws_r, ws_nxt;
  logic [ACC_W-1:0] wcs_r, wcs_nxt, wrs_r, wrs_nxt;
  logic [WS_W:0]    ws_sum;
  logic [ACC_W:0]   wcs_sum, wrs_sum;

  logic             div_busy_r, nospot_r;
  logic             div_start, div_ack, out_load;
  logic             xv, yv;
  logic [OUT_W-1:0] qx, qy;

  logic             out_valid_r, out_no_spot_r;
  logic [OUT_W-1:0] out_x_r, out_y_r;

  always_comb begin
    {it_last, it_weight, it_wcol, it_wrow} = q_data;
    ws_sum  = (WS_W + 1)'(ws_r) + (WS_W + 1)'(it_weight);
    wcs_sum = (ACC_W + 1)'(wcs_r) + (ACC_W + 1)'(it_wcol);
    wrs_sum = (ACC_W + 1)'(wrs_r) + (ACC_W + 1)'(it_wrow);
    ws_nxt  = ws_sum[WS_W]   ? '1 : ws_sum[WS_W-1:0];
    wcs_nxt = wcs_sum[ACC_W] ? '1 : wcs_sum[ACC_W-1:0];
    wrs_nxt = wrs_sum[ACC_W] ? '1 : wrs_sum[ACC_W-1:0];
  end

  // a frame-end word waits while the previous frame's divide is in flight
  assign q_pop     = !q_empty && (!it_last || !div_busy_r);
  assign div_start = q_pop && it_last;
  assign out_load  = div_busy_r && xv && yv && (!out_valid_r || !out_stall);
  assign div_ack   = out_load;

  tsc_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .num       (wcs_nxt),
    .den       (ws_nxt),
    .ack       (div_ack),
    .res_valid (xv),
    .quot      (qx)
  );

  tsc_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .num       (wrs_nxt),
    .den       (ws_nxt),
    .ack       (div_ack),
    .res_valid (yv),
    .quot      (qy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r        <= '0;
      wcs_r       <= '0;
      wrs_r       <= '0;
      div_busy_r  <= 1'b0;
      nospot_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        if (it_last) begin
          ws_r       <= '0;
          wcs_r      <= '0;
          wrs_r      <= '0;
          nospot_r   <= (ws_nxt == '0);
          div_busy_r <= 1'b1;
        end else begin
          ws_r  <= ws_nxt;
          wcs_r <= wcs_nxt;
          wrs_r <= wrs_nxt;
        end
      end
      if (out_load) begin
        div_busy_r    <= 1'b0;
        out_valid_r   <= 1'b1;
        out_no_spot_r <= nospot_r;
        out_x_r       <= nospot_r ? '0 : qx;
        out_y_r       <= nospot_r ? '0 : qy;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_centroid_x = out_x_r;
  assign out_centroid_y = out_y_r;
  assign out_no_spot    = out_no_spot_r;

endmodule

>>> hw/rtl/thresholded_spot_centroid.sv
// Top level of the thresholded spot centroid: config registers and the front/back split.
//
//  channel | direction | handshake            | word
//  in_     | input     | in_valid / in_stall  | pixel_value, frame_end
//  out_    | output    | out_valid / out_stall| centroid_x, centroid_y, no_spot
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One pixel a cycle while in_stall is low; words cross a QUEUE_DEPTH-entry queue to the accumulators.
// A frame-end word starts two dividers (one quotient bit a cycle), running while
// the next frame's pixels accumulate.
// A second frame-end word waits in the queue until the previous result has been
// moved into the output register; out_stall holds that register and so that word.
// Synchronous reset clears counters, accumulators and sets the config defaults.
`timescale 1ns / 1ps

module thresholded_spot_centroid
  import tsc_pkg::*;
#(
  parameter int MAX_COLS  = DEF_MAX_COLS,
  parameter int MAX_ROWS  = DEF_MAX_ROWS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      in_pixel_value,
  input  logic                  in_frame_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_W-1:0]      out_centroid_x,
  output logic [OUT_W-1:0]      out_centroid_y,
  output logic                  out_no_spot,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int IW = 1 + PIX_W + (PIX_W + CW) + (PIX_W + RW);

  logic [THRESH_W-1:0]    threshold_r;
  logic [ROW_WIDTH_W-1:0] row_width_r;

  logic          q_push, q_pop, q_full, q_empty;
  logic [IW-1:0] q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESH_RST;
      row_width_r <= ROW_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold_r <= cfg_data[THRESH_W-1:0];
        REG_ROW_WIDTH: row_width_r <= cfg_data[ROW_WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  tsc_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .CW       (CW),
    .RW       (RW),
    .IW       (IW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .threshold      (threshold_r),
    .row_width      (row_width_r),
    .in_valid       (in_valid),
    .in_pixel_value (in_pixel_value),
    .in_frame_end   (in_frame_end),
    .q_full         (q_full),
    .in_stall       (in_stall),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  tsc_fifo #(
    .WIDTH (IW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  tsc_back #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .FRAC_BITS (FRAC_BITS),
    .CW        (CW),
    .RW        (RW),
    .IW        (IW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_centroid_x (out_centroid_x),
    .out_centroid_y (out_centroid_y),
    .out_no_spot    (out_no_spot)
  );

endmodule

>>> tb/sv/thresholded_spot_centroid_tb.sv
// Self-checking testbench for the thresholded spot centroid: predicts each frame's centroid.
`timescale 1ns / 1ps

module thresholded_spot_centroid_tb;
  import tsc_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int SETTLE_CYCLES = 64;   // queue, dividers and output register, with margin
  localparam int COL_W         = 10;
  localparam int ROW_W         = 10;
  localparam int RANDOM_PIXELS = 480;  // the long frame below brings the total near 1700
  localparam int PARTS         = 4;    // config changes per idling mode
  localparam int LONG_FRAME    = 1100; // enough rows to pin the row index at one width

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic             no_spot;
  } centroid_t;

  typedef enum int {FRAME_UNIFORM, FRAME_SPOT, FRAME_BLANK} frame_style_e;

  // Tracks raster position and weighted sums, and holds the centroids still owed.
  class frame_centroids;
    logic [THRESH_W-1:0]    threshold;
    logic [ROW_WIDTH_W-1:0] row_width;
    logic [COL_W-1:0]       column;
    logic [ROW_W-1:0]       row;
    logic [ACC_W-1:0]       col_sum;
    logic [ACC_W-1:0]       row_sum;
    logic [WS_W-1:0]        weight_sum;
    centroid_t              owed[$];
    int                     errors;

    function new();
      threshold  = THRESH_RST;
      row_width  = ROW_WIDTH_RST;
      errors     = 0;
      clear();
    endfunction

    function void clear();
      column     = '0;
      row        = '0;
      col_sum    = '0;
      row_sum    = '0;
      weight_sum = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_THRESHOLD: threshold = data[THRESH_W-1:0];
        REG_ROW_WIDTH: row_width = data;
        default: ;
      endcase
    endfunction

    function logic [ACC_W-1:0] acc_add(logic [ACC_W-1:0] acc, logic [ACC_W-1:0] add);
      logic [ACC_W:0] s;
      s = (ACC_W + 1)'(acc) + (ACC_W + 1)'(add);
      return s[ACC_W] ? '1 : s[ACC_W-1:0];
    endfunction

    function logic [OUT_W-1:0] scale(logic [ACC_W-1:0] num);
      logic [63:0] q;
      q = 64'(num) << DEF_FRAC_BITS;
      q = q / 64'(weight_sum);
      return (q > 64'(2 ** OUT_W - 1)) ? '1 : q[OUT_W-1:0];
    endfunction

    function void take_pixel(logic [PIX_W-1:0] pix, logic last);
      logic [PIX_W-1:0]       w;
      logic [ACC_W-1:0]       term;
      logic [WS_W:0]          ws;
      logic [ROW_WIDTH_W-1:0] width;
      logic [COL_W:0]         next_col;
      centroid_t              r;
      width = row_width;
      if (width == '0) width = ROW_WIDTH_W'(1);
      if (width > ROW_WIDTH_W'(DEF_MAX_COLS)) width = ROW_WIDTH_W'(DEF_MAX_COLS);
      if (pix <= threshold) begin
        w          = PIX_W'(PIX_MAX) - pix;
        ws         = (WS_W + 1)'(weight_sum) + (WS_W + 1)'(w);
        weight_sum = ws[WS_W] ? '1 : ws[WS_W-1:0];
        term       = ACC_W'(w) * ACC_W'(column);
        col_sum    = acc_add(col_sum, term);
        term       = ACC_W'(w) * ACC_W'(row);
        row_sum    = acc_add(row_sum, term);
      end
      next_col = (COL_W + 1)'(column) + (COL_W + 1)'(1);
      if (next_col >= width) begin
        column = '0;
        if (row < ROW_W'(DEF_MAX_ROWS - 1)) row = row + ROW_W'(1);
      end else begin
        column = next_col[COL_W-1:0];
      end
      if (last) begin
        if (weight_sum == '0) begin
          r = '{x: '0, y: '0, no_spot: 1'b1};
        end else begin
          r = '{x: scale(col_sum), y: scale(row_sum), no_spot: 1'b0};
        end
        owed.push_back(r);
        clear();
      end
    endfunction

    function void match_centroid(centroid_t got);
      centroid_t want;
      if (owed.size() == 0) begin
        $display("%0t: centroid word with none owed: x=%0d y=%0d no_spot=%0b",
                 $time, got.x, got.y, got.no_spot);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.no_spot !== want.no_spot) begin
        $display("%0t: no_spot expected %0b actual %0b", $time, want.no_spot, got.no_spot);
        errors++;
      end
      if (got.x !== want.x) begin
        $display("%0t: centroid_x expected %0d actual %0d", $time, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: centroid_y expected %0d actual %0d", $time, want.y, got.y);
        errors++;
      end
    endfunction
  endclass

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_pixel_value = '0;
  logic                  in_frame_end   = 1'b0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic [OUT_W-1:0]      out_centroid_x;
  logic [OUT_W-1:0]      out_centroid_y;
  logic                  out_no_spot;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  frame_centroids book;

  thresholded_spot_centroid u_dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      book.match_centroid('{x: out_centroid_x, y: out_centroid_y, no_spot: out_no_spot});
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_pixel_value = pix;
    in_frame_end   = last;
    do begin
      @(posedge clk);
    end while (in_stall);
    book.take_pixel(pix, last);
    @(negedge clk);
  endtask

  task automatic await_centroids();
    in_valid = 1'b0;
    while (book.owed.size() != 0) @(negedge clk);
  endtask

  // Frame-less words leave no trace at the output, so give the pipe time to empty.
  task automatic drain();
    await_centroids();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    book.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_config();
    logic [CFG_DATA_W-1:0]  th;
    logic [ROW_WIDTH_W-1:0] rw;
    th = CFG_DATA_W'($urandom);  // spare upper bits ride along with the threshold
    case ($urandom_range(0, 5))
      0:       th[THRESH_W-1:0] = '0;
      1:       th[THRESH_W-1:0] = '1;
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0:       rw = ROW_WIDTH_W'(1);
      1:       rw = ROW_WIDTH_W'(DEF_MAX_COLS);
      2:       rw = '0;
      3:       rw = ROW_WIDTH_W'($urandom_range(DEF_MAX_COLS + 1, 2 ** ROW_WIDTH_W - 1));
      4:       rw = ROW_WIDTH_W'($urandom_range(1, DEF_MAX_COLS));
      default: rw = ROW_WIDTH_W'($urandom_range(2, 16));
    endcase
    write_reg(REG_THRESHOLD, th);
    write_reg(REG_ROW_WIDTH, rw);
  endtask

  // Spot frames: bright background with dark pixels; blank frames stay above threshold unless it is 255.
  function automatic logic [PIX_W-1:0] pick_pixel(frame_style_e style);
    logic [PIX_W-1:0] p;
    p = PIX_W'($urandom_range(0, PIX_MAX));
    if (book.threshold != PIX_W'(PIX_MAX)) begin
      if (style == FRAME_BLANK || (style == FRAME_SPOT && $urandom_range(0, 3) != 0)) begin
        p = PIX_W'($urandom_range(book.threshold + 1, PIX_MAX));
      end else if (style == FRAME_SPOT) begin
        p = PIX_W'($urandom_range(0, book.threshold));
      end
    end
    return p;
  endfunction

  task automatic send_frame(input int len, input frame_style_e style, input bit hold);
    for (int i = 0; i < len; i++) begin
      if (hold && i == len / 2) await_centroids();
      send_pixel(pick_pixel(style), i == len - 1);
    end
  endtask

  initial begin
    frame_style_e style;
    int           sent;
    int           len;
    book = new();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset config: single-pixel frames, pixel at threshold, one just above
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd128, 1'b0); send_pixel(8'd129, 1'b0); send_pixel(8'd0, 1'b1);
    drain();
    // zero row width acts as one; counted pixels of weight zero give no spot
    write_reg(REG_THRESHOLD, 11'd255);
    write_reg(REG_ROW_WIDTH, 11'd0);
    send_pixel(8'd255, 1'b0); send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0); send_pixel(8'd255, 1'b0);
    send_pixel(8'd170, 1'b0); send_pixel(8'd85, 1'b1);
    drain();
    // oversize row width clamps
    write_reg(REG_THRESHOLD, 11'd0);
    write_reg(REG_ROW_WIDTH, 11'd2047);
    send_pixel(8'd0, 1'b0); send_pixel(8'd1, 1'b0); send_pixel(8'd0, 1'b1);
    send_pixel(8'd1, 1'b1);
    drain();
    write_reg(REG_THRESHOLD, 11'd200);
    write_reg(REG_ROW_WIDTH, 11'd3);
    send_pixel(8'd255, 1'b0); send_pixel(8'd0, 1'b0); send_pixel(8'd200, 1'b0);
    send_pixel(8'd201, 1'b0); send_pixel(8'd85, 1'b0); send_pixel(8'd170, 1'b0);
    send_pixel(8'd0, 1'b1);

    for (int mode = 0; mode < 3; mode++) begin
      drain();
      case (mode)
        0:       begin send_idle_pct = 27; recv_idle_pct = 81; end
        1:       begin send_idle_pct = 81; recv_idle_pct = 27; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int part = 0; part < PARTS; part++) begin
        drain();
        random_config();
        sent = 0;
        for (int f = 0; sent < RANDOM_PIXELS / (3 * PARTS); f++) begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 24);
          case ($urandom_range(0, 5))
            0, 1, 2: style = FRAME_SPOT;
            3, 4:    style = FRAME_UNIFORM;
            default: style = FRAME_BLANK;
          endcase
          // second frame of each part pauses mid-frame until no centroid is owed
          send_frame(len, style, f == 1);
          sent += len;
        end
      end
    end

    // one pixel per row, more rows than the row index can count
    drain();
    write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(64, PIX_MAX)));
    write_reg(REG_ROW_WIDTH, 11'd1);
    send_frame(LONG_FRAME, FRAME_SPOT, 1'b0);

    drain();
    if (book.errors == 0) begin
      $display("thresholded_spot_centroid_tb: clean");
    end else begin
      $display("thresholded_spot_centroid_tb: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("thresholded_spot_centroid_tb: errors");
    $finish;
  end

endmodule

>>> thresholded_spot_centroid.f
hw/rtl/tsc_pkg.sv
hw/rtl/tsc_fifo.sv
hw/rtl/tsc_front.sv
hw/rtl/tsc_div.sv
hw/rtl/tsc_back.sv
hw/rtl/thresholded_spot_centroid.sv
tb/sv/thresholded_spot_centroid_tb.sv
